// ===== hw/rtl/barcode_hamming_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// barcode_hamming_matcher_defines
// Assertion macros used by the barcode matcher port checks.
// ----------------------------------------------------------------------------
`ifndef BARCODE_HAMMING_MATCHER_DEFINES_SVH
`define BARCODE_HAMMING_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bhm_pkg.sv =====
// ----------------------------------------------------------------------------
// bhm_pkg
// Types and constants of the barcode Hamming-distance matcher.
// ----------------------------------------------------------------------------
package bhm_pkg;

  localparam int BHM_ENTRIES   = 32;
  localparam int BHM_TAG_CHARS = 7;

  localparam int CHAR_W    = 8;
  localparam int PORT_W    = 56;          // packed character field on the ports
  localparam int PAD_W     = CHAR_W * 8;  // port field padded to eight characters
  localparam int LEN_W     = 3;
  localparam int LEN_MAX   = 7;
  localparam int CNT_W     = 4;
  localparam int LIMIT_W   = 4;
  localparam int IDX_OUT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } bhm_state_t;

  typedef struct packed {
    logic clr_wr;    // clearing pass writes an empty entry at the counter
    logic load_wr;   // load transfer writes the entry from the input ports
    logic seq_ld;    // capture the query characters
    logic scan_rd;   // read the entry at the counter and step it
    logic addr_clr;  // return the counter to zero
    logic res_ld;    // capture the scan outcome
    logic out_ld;    // move the outcome into the output register
  } bhm_cmd_t;

  typedef struct packed {
    logic addr_last;  // counter sits on the last entry
    logic hit;        // entry read last cycle is valid and its mismatch count is below the limit
  } bhm_sts_t;

endpackage

// ===== hw/rtl/bhm_dp.sv =====
// ----------------------------------------------------------------------------
// bhm_dp
// Tag store, scan counter, mismatch counter and result registers.
// ----------------------------------------------------------------------------
module bhm_dp import bhm_pkg::*; #(
  parameter int ENTRIES   = BHM_ENTRIES,
  parameter int TAG_CHARS = BHM_TAG_CHARS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bhm_cmd_t             cmd,
  output bhm_sts_t             sts,
  input  logic [4:0]           in_entry_index,
  input  logic [PORT_W-1:0]    in_entry_tag,
  input  logic [LEN_W-1:0]     in_entry_length,
  input  logic                 in_entry_valid,
  input  logic [PORT_W-1:0]    in_query_seq,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  output logic                 out_matched,
  output logic [IDX_OUT_W-1:0] out_match_index
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TAG_W   = CHAR_W * TAG_CHARS;
  localparam int ENT_W   = TAG_W + LEN_W + 1;
  localparam int MAX_LEN = (TAG_CHARS > LEN_MAX) ? LEN_MAX : TAG_CHARS;

  logic [ENT_W-1:0]     mem [ENTRIES];
  logic [ENT_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_vld_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [TAG_W-1:0]     seq_r;
  logic                 res_found_r;
  logic [IDX_OUT_W-1:0] res_idx_r;
  logic                 out_matched_r;
  logic [IDX_OUT_W-1:0] out_idx_r;

  logic [PAD_W-1:0]     tag_pad, seq_pad;
  logic [TAG_W-1:0]     ld_tag, ld_seq;
  logic [LEN_W-1:0]     ld_len;
  logic                 idx_ok;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;

  logic                 rd_vld;
  logic [LEN_W-1:0]     rd_len;
  logic [TAG_W-1:0]     rd_tag;
  logic [CNT_W-1:0]     mis_cnt;

  // ---- load path ----
  always_comb begin
    tag_pad = PAD_W'(in_entry_tag);
    seq_pad = PAD_W'(in_query_seq);
    for (int i = 0; i < TAG_CHARS; i++) begin
      ld_tag[CHAR_W*i +: CHAR_W] = tag_pad[CHAR_W*i +: CHAR_W];
      ld_seq[CHAR_W*i +: CHAR_W] = seq_pad[CHAR_W*i +: CHAR_W];
    end
    if (int'(in_entry_length) > MAX_LEN) begin
      ld_len = LEN_W'(MAX_LEN);
    end else begin
      ld_len = in_entry_length;
    end
  end

  assign idx_ok  = int'(in_entry_index) < ENTRIES;
  assign wr_en   = cmd.clr_wr | (cmd.load_wr & idx_ok);
  assign wr_addr = cmd.clr_wr ? addr_r : IDX_W'(in_entry_index);
  assign wr_data = cmd.clr_wr ? '0 : {in_entry_valid, ld_len, ld_tag};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= mem[addr_r];
      cmp_idx_r <= addr_r;
    end
    if (cmd.seq_ld) begin
      seq_r <= ld_seq;
    end
  end

  // ---- scan counter ----
  always_comb begin
    if (cmd.addr_clr) begin
      addr_nxt = '0;
    end else if (cmd.clr_wr || cmd.scan_rd) begin
      addr_nxt = addr_r + IDX_W'(1);
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
      limit_r   <= LIMIT_RESET;
    end else begin
      addr_r    <= addr_nxt;
      cmp_vld_r <= cmd.scan_rd;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // ---- mismatch count over the entry's own length ----
  assign rd_vld = rd_data_r[ENT_W-1];
  assign rd_len = rd_data_r[TAG_W +: LEN_W];
  assign rd_tag = rd_data_r[TAG_W-1:0];

  always_comb begin
    mis_cnt = '0;
    for (int i = 0; i < TAG_CHARS; i++) begin
      if ((i < int'(rd_len)) &&
          (rd_tag[CHAR_W*i +: CHAR_W] != seq_r[CHAR_W*i +: CHAR_W])) begin
        mis_cnt = mis_cnt + CNT_W'(1);
      end
    end
  end

  assign sts.hit       = cmp_vld_r & rd_vld & (mis_cnt < limit_r);
  assign sts.addr_last = (addr_r == IDX_W'(ENTRIES - 1));

  // ---- result and output registers ----
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_found_r <= sts.hit;
      res_idx_r   <= sts.hit ? IDX_OUT_W'(cmp_idx_r) : '0;
    end
    if (cmd.out_ld) begin
      out_matched_r <= res_found_r;
      out_idx_r     <= res_idx_r;
    end
  end

  assign out_matched     = out_matched_r;
  assign out_match_index = out_idx_r;

endmodule

// ===== hw/rtl/bhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhm_ctrl
// Sequencer for the clearing pass, loads, table scans and result transfer.
// ----------------------------------------------------------------------------
module bhm_ctrl import bhm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  bhm_sts_t sts,
  output bhm_cmd_t cmd
);

  bhm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.addr_last) begin
          cmd.addr_clr = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd == CMD_QUERY) begin
            cmd.seq_ld = 1'b1;
            state_nxt  = ST_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // first hit in index order ends the walk
        if (sts.hit) begin
          cmd.res_ld   = 1'b1;
          cmd.addr_clr = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          if (sts.addr_last) begin
            cmd.addr_clr = 1'b1;
            state_nxt    = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd.res_ld = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/barcode_hamming_matcher.sv =====
// ----------------------------------------------------------------------------
// barcode_hamming_matcher
// Barcode tag table with first-match search by character mismatch count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): a load (in_cmd = 0) writes or clears one table slot
//   and gives no result; a query (in_cmd = 1) gives one result on out_*.
//   Both channels transfer on valid high and stall low.
//   cfg_wr_en/cfg_wr_data set the mismatch limit (reset value 1); write it
//   only while no query is in flight.
// Timing:
//   A query walks the table one entry per cycle out of a single-port read of
//   the tag memory with registered read data; the first hit in index order,
//   or the last entry, ends the scan, and the result then moves into the
//   output register once it is free. The input is open again from the cycle
//   in which out_valid rises; a new item is not taken while a query is in flight.
// Reset:
//   rst_n clears the valid marks by a pass over the memory that walks every
//   entry; in_stall stays high during it.
// Stall:
//   A result waits in the output register while out_stall is high; the block
//   still takes the next item and finishes its scan, then holds it until
//   the output register frees up.
// ----------------------------------------------------------------------------
module barcode_hamming_matcher import bhm_pkg::*; #(
  parameter int ENTRIES   = BHM_ENTRIES,
  parameter int TAG_CHARS = BHM_TAG_CHARS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [4:0]           in_entry_index,
  input  logic [PORT_W-1:0]    in_entry_tag,
  input  logic [LEN_W-1:0]     in_entry_length,
  input  logic                 in_entry_valid,
  input  logic [PORT_W-1:0]    in_query_seq,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_matched,
  output logic [IDX_OUT_W-1:0] out_match_index,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  bhm_cmd_t cmd;
  bhm_sts_t sts;

  bhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhm_dp #(
    .ENTRIES   (ENTRIES),
    .TAG_CHARS (TAG_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_entry_tag    (in_entry_tag),
    .in_entry_length (in_entry_length),
    .in_entry_valid  (in_entry_valid),
    .in_query_seq    (in_query_seq),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_matched     (out_matched),
    .out_match_index (out_match_index)
  );

endmodule

// ===== hw/rtl/bhm_chk.sv =====
// ----------------------------------------------------------------------------
// bhm_chk
// Port-level checks of the barcode matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "barcode_hamming_matcher_defines.svh"

module bhm_chk import bhm_pkg::*; #(
  parameter int ENTRIES = BHM_ENTRIES
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_cmd,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_matched,
  input logic [IDX_OUT_W-1:0] out_match_index
);

  // stalled result holds
  `BHM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_matched) && $stable(out_match_index), "result changed under stall")

  // a miss reports slot zero
  `BHM_ASSERT_NOW(a_miss_idx, out_valid && !out_matched, out_match_index == '0, "miss with nonzero index")

  // reported slot lies in the table
  `BHM_ASSERT_NOW(a_idx_range, out_valid && out_matched, (ENTRIES > 32) || (int'(out_match_index) < ENTRIES), "match index beyond table")

  // out_valid does not rise in the cycle after a query transfer
  `BHM_ASSERT_NEXT(a_query_lat, in_valid && !in_stall && (in_cmd == CMD_QUERY), !$rose(out_valid), "result too early after query")

  // input stalled when reset has just been released, as the clearing pass starts
  `BHM_ASSERT_NOW(a_reset_clear, $past(!rst_n), in_stall, "input open right after reset")

endmodule

bind barcode_hamming_matcher bhm_chk #(.ENTRIES(ENTRIES)) u_bhm_chk (.*);

// ===== sim/barcode_hamming_matcher_checker.sv =====
// ----------------------------------------------------------------------------
// barcode_hamming_matcher_checker
// Watches the load/query and result channels of the barcode matcher, keeps
// its own copy of the tag table and the mismatch limit, and compares every
// result transfer with the first hit predicted for the oldest open query.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module barcode_hamming_matcher_checker import bhm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [4:0]           in_entry_index,
  input  logic [PORT_W-1:0]    in_entry_tag,
  input  logic [LEN_W-1:0]     in_entry_length,
  input  logic                 in_entry_valid,
  input  logic [PORT_W-1:0]    in_query_seq,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_matched,
  input  logic [IDX_OUT_W-1:0] out_match_index,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  output int unsigned          mismatch_count,
  output int unsigned          results_owed
);

  typedef struct packed {
    logic                 matched;
    logic [IDX_OUT_W-1:0] slot;
  } hit_t;

  logic [PORT_W-1:0]  tag_copy  [BHM_ENTRIES];
  logic [LEN_W-1:0]   len_copy  [BHM_ENTRIES];
  logic               live_copy [BHM_ENTRIES];
  logic [LIMIT_W-1:0] limit_copy;
  hit_t               owed_hits [$];

  function automatic int unsigned char_diffs(logic [PORT_W-1:0] tag,
                                             logic [PORT_W-1:0] seq,
                                             logic [LEN_W-1:0]  len);
    int unsigned n;
    int          i;
    n = 0;
    for (i = 0; i < BHM_TAG_CHARS; i++)
      if (i < len && tag[i*CHAR_W +: CHAR_W] != seq[i*CHAR_W +: CHAR_W]) n++;
    return n;
  endfunction

  // walk from the top so the lowest hitting slot is the one left standing
  function automatic hit_t predict_first_hit(logic [PORT_W-1:0] seq);
    hit_t h;
    int   i;
    h = '0;
    for (i = BHM_ENTRIES - 1; i >= 0; i--)
      if (live_copy[i] && char_diffs(tag_copy[i], seq, len_copy[i]) < limit_copy) begin
        h.matched = 1'b1;
        h.slot    = i[IDX_OUT_W-1:0];
      end
    return h;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    int               k;
    hit_t             want;
    logic [LEN_W-1:0] len;
    if (!rst_n) begin
      for (k = 0; k < BHM_ENTRIES; k++) begin
        tag_copy[k]  = '0;
        len_copy[k]  = '0;
        live_copy[k] = 1'b0;
      end
      limit_copy     = LIMIT_RESET;
      owed_hits.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) limit_copy = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_LOAD) begin
          if (in_entry_index < BHM_ENTRIES) begin
            len = in_entry_length;
            if (len > BHM_TAG_CHARS) len = LEN_W'(BHM_TAG_CHARS);
            tag_copy[in_entry_index]  = in_entry_tag;
            len_copy[in_entry_index]  = len;
            live_copy[in_entry_index] = in_entry_valid;
          end
        end else begin
          owed_hits.push_back(predict_first_hit(in_query_seq));
        end
      end
      if (out_valid && !out_stall) begin
        if (owed_hits.size() == 0) begin
          report_mismatch("result transfer with no open query, match_index",
                          out_match_index, 0);
        end else begin
          want = owed_hits.pop_front();
          if (out_matched !== want.matched)
            report_mismatch("matched", out_matched, want.matched);
          if (out_match_index !== want.slot)
            report_mismatch("match_index", out_match_index, want.slot);
        end
      end
    end
    results_owed <= owed_hits.size();
  end

endmodule

// ===== sim/barcode_hamming_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// barcode_hamming_matcher_tb
// Drives loads and queries into the barcode matcher under random idling on
// both sides, steps the mismatch limit through values from 0 to 8 between
// phases and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module barcode_hamming_matcher_tb;
  import bhm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = BHM_ENTRIES + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [PORT_W-1:0] ALL_ONES = '1;
  localparam logic [PORT_W-1:0] ACGTACG  = 56'h47_43_41_54_47_43_41;
  localparam logic [PORT_W-1:0] T_RUN    = {7{8'h54}};

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_cmd          = CMD_LOAD;
  logic [4:0]           in_entry_index  = '0;
  logic [PORT_W-1:0]    in_entry_tag    = '0;
  logic [LEN_W-1:0]     in_entry_length = '0;
  logic                 in_entry_valid  = 1'b0;
  logic [PORT_W-1:0]    in_query_seq    = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic                 out_matched;
  logic [IDX_OUT_W-1:0] out_match_index;
  logic                 cfg_wr_en       = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data     = '0;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          hold_rx = 1'b0;

  // what was loaded, only used to aim queries near live tags
  logic [PORT_W-1:0] sent_tags [BHM_ENTRIES];
  bit                sent_live [BHM_ENTRIES];

  logic [LIMIT_W-1:0] phase_limits [7] = '{4'd2, 4'd7, 4'd0, 4'd3, 4'd8, 4'd1, 4'd4};

  barcode_hamming_matcher u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_entry_tag    (in_entry_tag),
    .in_entry_length (in_entry_length),
    .in_entry_valid  (in_entry_valid),
    .in_query_seq    (in_query_seq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  barcode_hamming_matcher_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_entry_tag    (in_entry_tag),
    .in_entry_length (in_entry_length),
    .in_entry_valid  (in_entry_valid),
    .in_query_seq    (in_query_seq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] base_char();
    case ($urandom_range(0, 3))
      0:       return 8'h41;
      1:       return 8'h43;
      2:       return 8'h47;
      default: return 8'h54;
    endcase
  endfunction

  // small alphabet most of the time so chance hits happen, full bytes otherwise
  function automatic logic [PORT_W-1:0] rand_tag();
    logic [PORT_W-1:0] t;
    int                i;
    bit                dna;
    dna = ($urandom_range(0, 9) < 6);
    for (i = 0; i < BHM_TAG_CHARS; i++)
      t[i*CHAR_W +: CHAR_W] = dna ? base_char() : CHAR_W'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 20) return LEN_W'($urandom_range(1, 3));
    return LEN_W'($urandom_range(4, LEN_MAX));
  endfunction

  // a live tag with up to three characters disturbed
  function automatic logic [PORT_W-1:0] near_seq();
    logic [PORT_W-1:0] s;
    int                tries;
    int                slot;
    int                k;
    int                p;
    s = rand_tag();
    for (tries = 0; tries < 8; tries++) begin
      slot = $urandom_range(0, BHM_ENTRIES - 1);
      if (sent_live[slot]) begin
        s = sent_tags[slot];
        for (k = $urandom_range(0, 3); k > 0; k--) begin
          p = $urandom_range(0, BHM_TAG_CHARS - 1);
          s[p*CHAR_W +: CHAR_W] ^= CHAR_W'($urandom_range(1, 255));
        end
        break;
      end
    end
    return s;
  endfunction

  // called at a clock edge; leaves valid high when the next transfer follows at once
  task automatic offer_item(logic cmd, logic [4:0] idx, logic [PORT_W-1:0] tag,
                            logic [LEN_W-1:0] len, logic keep, logic [PORT_W-1:0] seq);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_entry_index  <= idx;
    in_entry_tag    <= tag;
    in_entry_length <= len;
    in_entry_valid  <= keep;
    in_query_seq    <= seq;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = (burst_left > 0) ? 0 : idle_len();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_slot(logic [4:0] idx, logic [PORT_W-1:0] tag,
                           logic [LEN_W-1:0] len, logic keep);
    offer_item(CMD_LOAD, idx, tag, len, keep, rand_tag());
    sent_tags[idx] = tag;
    sent_live[idx] = keep;
  endtask

  task automatic query_read(logic [PORT_W-1:0] seq);
    offer_item(CMD_QUERY, 5'($urandom_range(0, 31)), rand_tag(),
               LEN_W'($urandom_range(0, LEN_MAX)), 1'($urandom_range(0, 1)), seq);
  endtask

  // sender pauses until every result is back and the last load has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++) begin
      if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
      if ($urandom_range(0, 99) < 35)
        load_slot(5'($urandom_range(0, 31)), rand_tag(), rand_len(),
                  $urandom_range(0, 99) < 85);
      else if ($urandom_range(0, 99) < 70)
        query_read(near_seq());
      else
        query_read(rand_tag());
    end
  endtask

  // result side: random stall runs, a long free stretch now and then,
  // and one long hold-off on request
  initial begin : rx_side
    int unsigned run;
    bit          stop_now;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        stop_now = 1'b1;
        run      = HOLD_CYCLES;
        hold_rx  = 1'b0;
      end else begin
        stop_now = ($urandom_range(0, 2) == 0);
        run      = idle_len();
        if (run == 0) run = 1;
        if (!stop_now && $urandom_range(0, 9) == 0) run = $urandom_range(50, 150);
      end
      out_stall <= stop_now;
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // limit at its reset value of one
    query_read('0);                         // empty table
    load_slot(5'd0, '0, 3'd7, 1'b1);
    query_read(ALL_ONES);                   // every character differs
    query_read('0);
    load_slot(5'd31, ALL_ONES, 3'd7, 1'b1);
    query_read(ALL_ONES);
    load_slot(5'd0, ALL_ONES, 3'd7, 1'b0);  // clearing load still writes the tag
    query_read(ALL_ONES);
    load_slot(5'd3, ACGTACG, 3'd3, 1'b1);
    query_read({32'hFFFF_FFFF, ACGTACG[23:0]});  // characters past the length ignored
    query_read(ACGTACG ^ (56'hFF << 16));
    load_slot(5'd7, ALL_ONES, 3'd0, 1'b1);  // zero length hits anything
    query_read('0);
    load_slot(5'd7, ALL_ONES, 3'd0, 1'b0);
    query_read('0);
    load_slot(5'd16, T_RUN, 3'd7, 1'b1);
    query_read({8'h41, T_RUN[47:0]});       // one miss in the last character
    query_read(T_RUN);

    set_limit(4'd0);                        // nothing can hit
    query_read(T_RUN);
    query_read('0);
    set_limit(4'd8);
    query_read('0);
    query_read(ALL_ONES);

    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p]);
      if (p == 3) begin
        // receiver holds off while the sender keeps pushing
        hold_rx    = 1'b1;
        burst_left = 40;
        random_traffic(40);
      end
      random_traffic(85);
    end

    drain_results();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
